>>> hw/rtl/bsu_pkg.sv
// ----------------------------------------------------------------------------
// bsu_pkg
// Shared types and codes for the bytecode operand stack.
// ----------------------------------------------------------------------------
`default_nettype none

package bsu_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned ErrW  = 3;
  localparam int unsigned DataW = 32;

  typedef enum logic [OpW-1:0] {
    OP_PUSH = 3'd0,
    OP_PALL = 3'd1,
    OP_PINT = 3'd2,
    OP_POP  = 3'd3,
    OP_SWAP = 3'd4
  } opcode_e;

  typedef enum logic [ErrW-1:0] {
    ERR_NONE       = 3'd0,
    ERR_OVERFLOW   = 3'd1,
    ERR_PINT_EMPTY = 3'd2,
    ERR_POP_EMPTY  = 3'd3,
    ERR_SWAP_SHORT = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PTOP,
    ST_PALL,
    ST_SWAP_A,
    ST_SWAP_B,
    ST_SWAP_C,
    ST_ERR
  } state_e;

endpackage

`default_nettype wire

>>> hw/rtl/bsu_ram.sv
// ----------------------------------------------------------------------------
// bsu_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module bsu_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> hw/rtl/bytecode_stack_unit.sv
// ----------------------------------------------------------------------------
// bytecode_stack_unit
// Operand stack of a small bytecode interpreter, kept in one synchronous RAM.
// ----------------------------------------------------------------------------
// timing: push and pop finish in the accepting cycle; print top and errors give their
// item in the cycle after accept; swap does read, read, write, write on the single
// RAM port pair; print all does one RAM read per stored value; results cannot be
// stalled.
// reset: asynchronous, clears the entry count and control; RAM is not cleared.
`default_nettype none

module bytecode_stack_unit #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  output logic             busy_o,
  input  wire logic [2:0]  opcode_i,
  input  wire logic signed [31:0] push_value_i,
  output logic             out_valid_o,
  output logic signed [31:0] out_value_o,
  output logic [2:0]       error_code_o,
  output logic             last_of_run_o
);

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned DW = bsu_pkg::DataW;

  bsu_pkg::state_e state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [AW-1:0]   idx_q, idx_d;
  logic [DW-1:0]   tmp_q, tmp_d;
  bsu_pkg::err_e   err_q, err_d;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [DW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [DW-1:0]   ram_rdata;

  logic [CW-1:0]   cnt_m1;
  logic [CW-1:0]   cnt_m2;
  logic [AW-1:0]   top_addr;
  logic [AW-1:0]   second_addr;
  logic            full;
  logic            empty;
  logic            accept;

  assign cnt_m1      = count_q - CW'(1);
  assign cnt_m2      = count_q - CW'(2);
  assign top_addr    = cnt_m1[AW-1:0];
  assign second_addr = cnt_m2[AW-1:0];
  assign full        = (count_q == CW'(STACK_DEPTH));
  assign empty       = (count_q == '0);
  assign accept      = start_i && (state_q == bsu_pkg::ST_IDLE);

  bsu_ram #(
    .WIDTH (DW),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bsu_pkg::ST_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      err_q   <= bsu_pkg::ERR_NONE;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tmp_q <= tmp_d;
  end

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    idx_d         = idx_q;
    tmp_d         = tmp_q;
    err_d         = err_q;
    ram_we        = 1'b0;
    ram_waddr     = top_addr;
    ram_wdata     = push_value_i;
    ram_raddr     = top_addr;
    out_valid_o   = 1'b0;
    out_value_o   = '0;
    error_code_o  = bsu_pkg::ERR_NONE;
    last_of_run_o = 1'b0;

    unique case (state_q)
      bsu_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (opcode_i)
            bsu_pkg::OP_PUSH: begin
              if (full) begin
                err_d   = bsu_pkg::ERR_OVERFLOW;
                state_d = bsu_pkg::ST_ERR;
              end else begin
                ram_we    = 1'b1;
                ram_waddr = count_q[AW-1:0];
                count_d   = count_q + CW'(1);
              end
            end
            bsu_pkg::OP_PALL: begin
              if (!empty) begin
                idx_d   = top_addr;
                state_d = bsu_pkg::ST_PALL;
              end
            end
            bsu_pkg::OP_PINT: begin
              if (empty) begin
                err_d   = bsu_pkg::ERR_PINT_EMPTY;
                state_d = bsu_pkg::ST_ERR;
              end else begin
                state_d = bsu_pkg::ST_PTOP;
              end
            end
            bsu_pkg::OP_POP: begin
              if (empty) begin
                err_d   = bsu_pkg::ERR_POP_EMPTY;
                state_d = bsu_pkg::ST_ERR;
              end else begin
                count_d = cnt_m1;
              end
            end
            bsu_pkg::OP_SWAP: begin
              if (count_q < CW'(2)) begin
                err_d   = bsu_pkg::ERR_SWAP_SHORT;
                state_d = bsu_pkg::ST_ERR;
              end else begin
                state_d = bsu_pkg::ST_SWAP_A;
              end
            end
            default: begin
            end
          endcase
        end
      end
      bsu_pkg::ST_PTOP: begin
        out_valid_o   = 1'b1;
        out_value_o   = ram_rdata;
        last_of_run_o = 1'b1;
        state_d       = bsu_pkg::ST_IDLE;
      end
      bsu_pkg::ST_PALL: begin
        out_valid_o   = 1'b1;
        out_value_o   = ram_rdata;
        last_of_run_o = (idx_q == '0);
        if (idx_q == '0) begin
          state_d = bsu_pkg::ST_IDLE;
        end else begin
          idx_d     = idx_q - AW'(1);
          ram_raddr = idx_q - AW'(1);
        end
      end
      bsu_pkg::ST_SWAP_A: begin
        tmp_d     = ram_rdata;
        ram_raddr = second_addr;
        state_d   = bsu_pkg::ST_SWAP_B;
      end
      bsu_pkg::ST_SWAP_B: begin
        ram_we    = 1'b1;
        ram_waddr = top_addr;
        ram_wdata = ram_rdata;
        state_d   = bsu_pkg::ST_SWAP_C;
      end
      bsu_pkg::ST_SWAP_C: begin
        ram_we    = 1'b1;
        ram_waddr = second_addr;
        ram_wdata = tmp_q;
        state_d   = bsu_pkg::ST_IDLE;
      end
      bsu_pkg::ST_ERR: begin
        out_valid_o   = 1'b1;
        error_code_o  = err_q;
        last_of_run_o = 1'b1;
        state_d       = bsu_pkg::ST_IDLE;
      end
      default: begin
        state_d = bsu_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != bsu_pkg::ST_IDLE);

  // results only come out of a busy cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni) out_valid_o |-> busy_o)
    else $error("result outside a busy cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(STACK_DEPTH))
    else $error("entry count beyond stack depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && opcode_i == bsu_pkg::OP_PUSH && !full) |=>
      count_q == $past(count_q) + CW'(1))
    else $error("push did not grow the stack");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsu_pkg::ST_ERR) |-> (error_code_o != bsu_pkg::ERR_NONE && last_of_run_o))
    else $error("error item without code");

  // swap writes back both entries in order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bsu_pkg::ST_SWAP_B) |=> (state_q == bsu_pkg::ST_SWAP_C && ram_we))
    else $error("swap write-back broken");

endmodule

`default_nettype wire
